@@ hdl/tcet_pkg.sv @@
// ----------------------------------------------------------------------------
// tcet_pkg
// shared types, constants and saturating helpers for the escape-time block
// ----------------------------------------------------------------------------
`default_nettype none

package tcet_pkg;

   localparam int ORBIT_DEPTH_DEF = 64;
   localparam int FRAC_BITS_DEF   = 28;

   localparam logic [63:0]        SATV  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic [1:0] {
      AS_IDLE,
      AS_RUN,
      AS_FIN
   } alu_state_type;

   typedef enum logic [1:0] {
      OUT_ESCAPED   = 2'd0,
      OUT_PERIODIC  = 2'd1,
      OUT_UNDECIDED = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      CSR_ROT_COS   = 3'd0,
      CSR_ROT_SIN   = 3'd1,
      CSR_MAX_ITER  = 3'd2,
      CSR_MAX_PER   = 3'd3,
      CSR_TOLERANCE = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_T_M0, S_T_M1, S_T_M2, S_T_M3,
      S_T_N0, S_T_N1, S_T_CHK, S_T_SQ,
      S_T_R0, S_T_R1, S_T_R2, S_T_R3,
      S_L_TOP, S_L_D0, S_L_D1, S_L_N0, S_L_N1, S_L_V0, S_L_V1,
      S_L_M0, S_L_M1, S_L_M2, S_L_M3,
      S_P_INIT, S_P_RD, S_P_S, S_P_Q0, S_P_Q1,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic         start;
      alu_op_type   op;
      logic [63:0]  opa;
      logic [63:0]  opb;
      logic [127:0] wide;
      logic         neg;
   } alu_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] res;
      logic [127:0]       prod;
   } alu_rsp_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic logic signed [63:0] sat_mag(input logic [63:0] m, input logic neg);
      logic [63:0] c;
      c = (m > SATV) ? SATV : m;
      return neg ? -$signed(c) : $signed(c);
   endfunction

   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > SMAX65) return SMAX;
      if (s < -SMAX65) return -SMAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
      return sadd(a, -b);
   endfunction

endpackage

`default_nettype wire

@@ hdl/tcet_ram.sv @@
// ----------------------------------------------------------------------------
// tcet_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tcet_ram #(
   parameter  int WIDTH = 128,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/tcet_alu.sv @@
// ----------------------------------------------------------------------------
// tcet_alu
// shared multi-cycle unit: 64x64 multiply on a 32x32 multiplier, 128/64
// restoring divide and 128-bit floor square root, one step a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tcet_alu #(
   parameter int FRAC_BITS = tcet_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tcet_pkg::alu_req_type req,
   output tcet_pkg::alu_rsp_type      rsp
);

   tcet_pkg::alu_state_type phase_ff, phase_in;
   tcet_pkg::alu_op_type    op_ff;
   logic               neg_ff;
   logic [5:0]         step_ff;
   logic [63:0]        a_ff, b_ff;
   logic [127:0]       acc_ff;
   logic [65:0]        rem_ff;
   logic [63:0]        root_ff;
   logic signed [63:0] res_ff;
   logic               done_ff;

   logic load_en, run_en, fin_en;
   logic div_ovf;
   logic [5:0] last_step;

   // multiply partial product
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   // divide step
   logic [64:0]  div_t, div_d;
   logic         div_ge;

   // square root step
   logic [65:0]  sq_r2, sq_trial;
   logic         sq_ge;

   logic [127:0]       mul_shifted;
   logic [63:0]        mul_mag;
   logic signed [63:0] fin_res;

   assign div_ovf   = req.wide[127:64] >= req.opb;
   assign last_step = (op_ff == tcet_pkg::ALU_MUL) ? 6'd3 : 6'd63;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         tcet_pkg::AS_IDLE: begin
            if (req.start) begin
               phase_in = (req.op == tcet_pkg::ALU_DIV && div_ovf) ?
                          tcet_pkg::AS_FIN : tcet_pkg::AS_RUN;
            end
         end
         tcet_pkg::AS_RUN: begin
            if (step_ff == last_step) phase_in = tcet_pkg::AS_FIN;
         end
         tcet_pkg::AS_FIN: phase_in = tcet_pkg::AS_IDLE;
         default:          phase_in = tcet_pkg::AS_IDLE;
      endcase
   end

   always_comb begin
      load_en = 1'b0;
      run_en  = 1'b0;
      fin_en  = 1'b0;
      unique case (phase_ff)
         tcet_pkg::AS_IDLE: load_en = req.start;
         tcet_pkg::AS_RUN:  run_en  = 1'b1;
         tcet_pkg::AS_FIN:  fin_en  = 1'b1;
         default: ;
      endcase
   end

   assign a_half = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp     = a_half * b_half;

   always_comb begin
      unique case (step_ff[1:0])
         2'b00:        pp_sh = {64'd0, pp};
         2'b01, 2'b10: pp_sh = {32'd0, pp, 32'd0};
         2'b11:        pp_sh = {pp, 64'd0};
         default:      pp_sh = {64'd0, pp};
      endcase
   end

   assign div_t  = acc_ff[127:63];
   assign div_d  = {1'b0, b_ff};
   assign div_ge = div_t >= div_d;

   assign sq_r2    = {rem_ff[63:0], acc_ff[127:126]};
   assign sq_trial = {root_ff, 2'b01};
   assign sq_ge    = sq_r2 >= sq_trial;

   assign mul_shifted = acc_ff >> FRAC_BITS;
   assign mul_mag     = (|mul_shifted[127:64]) ? '1 : mul_shifted[63:0];

   always_comb begin
      unique case (op_ff)
         tcet_pkg::ALU_MUL:  fin_res = tcet_pkg::sat_mag(mul_mag, neg_ff);
         tcet_pkg::ALU_DIV:  fin_res = tcet_pkg::sat_mag(acc_ff[63:0], neg_ff);
         tcet_pkg::ALU_SQRT: fin_res = $signed(root_ff);
         default:            fin_res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tcet_pkg::AS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= fin_en;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         op_ff   <= req.op;
         neg_ff  <= req.neg;
         a_ff    <= req.opa;
         b_ff    <= req.opb;
         step_ff <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
         if (req.op == tcet_pkg::ALU_MUL) begin
            acc_ff <= '0;
         end else if (req.op == tcet_pkg::ALU_DIV && div_ovf) begin
            acc_ff <= '1;
         end else begin
            acc_ff <= req.wide;
         end
      end else if (run_en) begin
         step_ff <= step_ff + 6'd1;
         unique case (op_ff)
            tcet_pkg::ALU_MUL: acc_ff <= acc_ff + pp_sh;
            tcet_pkg::ALU_DIV: begin
               acc_ff <= {div_ge ? 64'(div_t - div_d) : div_t[63:0], acc_ff[62:0], div_ge};
            end
            tcet_pkg::ALU_SQRT: begin
               acc_ff  <= {acc_ff[125:0], 2'b00};
               rem_ff  <= sq_ge ? (sq_r2 - sq_trial) : sq_r2;
               root_ff <= {root_ff[62:0], sq_ge};
            end
            default: ;
         endcase
      end else if (fin_en) begin
         res_ff <= fin_res;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.res  = res_ff;
   assign rsp.prod = acc_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> phase_ff == tcet_pkg::AS_IDLE)
      else $error("alu started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("alu done longer than one cycle");
   a_mul_steps: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tcet_pkg::AS_RUN && op_ff == tcet_pkg::ALU_MUL) |-> step_ff < 6'd4)
      else $error("multiply ran past its partial products");
`endif

endmodule

`default_nettype wire

@@ hdl/tricorn_escape_time_period.sv @@
// ----------------------------------------------------------------------------
// tricorn_escape_time_period
// work: each map step runs up to eight multiplies and two divides on the shared
//   unit, the period check two multiplies per kept orbit point, and setup six
//   multiplies, plus a root, four multiplies and two divides if a nonzero t is rescaled
// throughput: one point at a time; next point is taken once the sequencer is
//   back to idle, while the previous result may still wait on rsp
// reset: synchronous, active high; clears control and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module tricorn_escape_time_period #(
   parameter int ORBIT_DEPTH = tcet_pkg::ORBIT_DEPTH_DEF,
   parameter int FRAC_BITS   = tcet_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input point transfer
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // point_re [31:0], point_im [63:32]
   // result transfer
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // outcome [1:0], count [17:2], zero pad
   // register write port
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int OAW = (ORBIT_DEPTH > 1) ? $clog2(ORBIT_DEPTH) : 1;
   localparam int PW  = $clog2(ORBIT_DEPTH + 1);

   // fixed-point constants follow the fraction width
   localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;
   localparam logic [63:0] TENTH_Q     = (ONE_Q + 64'd5) / 64'd10;
   localparam logic [63:0] HUNDREDTH_Q = (ONE_Q + 64'd50) / 64'd100;
   localparam logic [63:0] LIM_CAP     = tcet_pkg::SATV / 64'd100;

   // configuration registers
   logic signed [31:0] rot_cos_ff, rot_sin_ff;
   logic [15:0]        max_iter_ff;
   logic [6:0]         max_per_ff;
   logic [30:0]        tol_ff;

   // sequencer state
   tcet_pkg::seq_state_type state_ff, state_in;
   logic wait_ff;
   logic pass2_ff;

   // working registers
   logic signed [63:0] ar_ff, ai_ff;       // point a
   logic signed [63:0] tr_ff, ti_ff;       // escape reference t
   logic signed [63:0] t0_ff;              // first product of a pair
   logic signed [63:0] nt_ff;              // |t|^2, then |x|^2 in the loop
   logic signed [63:0] lim_ff;             // 100*|t|^2
   logic signed [63:0] zr_ff, zi_ff;       // iterate x
   logic signed [63:0] wr_ff, wi_ff;       // x + 1/x, or distance in check
   logic [127:0]       wsum_ff;            // raw wide sum or product
   logic [63:0]        m_ff;               // |t| for rescaling
   logic [15:0]        cnt_ff;
   logic [PW-1:0]      per_ff, j_ff;

   // result held until the output slot is free
   tcet_pkg::outcome_type fin_outcome_ff;
   logic [15:0]           fin_count_ff;
   logic                  rsp_valid_ff;
   tcet_pkg::outcome_type rsp_outcome_ff;
   logic [15:0]           rsp_count_ff;

   // shared unit
   tcet_pkg::alu_req_type alu_req;
   tcet_pkg::alu_rsp_type alu_rsp;

   // operand selection
   logic                  is_call;
   tcet_pkg::alu_op_type  call_op;
   logic signed [63:0]    mul_a, mul_b;
   logic [127:0]          div_num;
   logic [63:0]           div_den;
   logic                  div_neg;

   // shared combinational terms
   logic signed [63:0] pair_sum, pair_diff;
   logic               escape_hit;
   logic               tol_hit;
   logic               rescale;
   logic [16:0]        per_cap;
   logic [16:0]        k_sum, k_idx;
   logic               store_hit;
   logic [PW-1:0]      rd_k;
   logic               slot_free;
   logic               accept;
   logic signed [63:0] inv_re_sat, inv_im_sat;
   logic [63:0]        lim_mul;

   // orbit store
   logic           ram_we;
   logic [OAW-1:0] ram_wr_addr, ram_rd_addr;
   logic [127:0]   ram_rd_data;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign pair_sum   = tcet_pkg::sadd(t0_ff, alu_rsp.res);
   assign pair_diff  = tcet_pkg::ssub(t0_ff, alu_rsp.res);
   assign escape_hit = pair_sum >= lim_ff;
   assign tol_hit    = pair_sum < $signed({33'd0, tol_ff});
   assign rescale    = !pass2_ff && (nt_ff < $signed(HUNDREDTH_Q));
   assign lim_mul    = (nt_ff << 6) + (nt_ff << 5) + (nt_ff << 2);

   // kept points: min(max_period, depth, max_iterations)
   always_comb begin
      per_cap = {10'd0, max_per_ff};
      if (per_cap > 17'(ORBIT_DEPTH)) per_cap = 17'(ORBIT_DEPTH);
      if (per_cap > {1'b0, max_iter_ff}) per_cap = {1'b0, max_iter_ff};
   end

   // the last per_ff iterates before the limit go to the store
   assign k_sum     = 17'(cnt_ff) + 17'(per_ff);
   assign store_hit = k_sum >= {1'b0, max_iter_ff};
   assign k_idx     = k_sum - {1'b0, max_iter_ff};

   assign ram_we      = (state_ff == tcet_pkg::S_L_D1) && alu_rsp.done && !escape_hit
                        && store_hit;
   assign ram_wr_addr = k_idx[OAW-1:0];
   assign rd_k        = per_ff - j_ff - {{(PW-1){1'b0}}, 1'b1};
   assign ram_rd_addr = rd_k[OAW-1:0];

   // reciprocal of zero saturates by the signs of x
   assign inv_re_sat = zr_ff[63] ? -tcet_pkg::SMAX : tcet_pkg::SMAX;
   assign inv_im_sat = (zi_ff > 0) ? -tcet_pkg::SMAX :
                       (zi_ff < 0) ? tcet_pkg::SMAX : 64'sd0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcet_pkg::S_IDLE:  if (accept) state_in = tcet_pkg::S_T_M0;
         tcet_pkg::S_T_M0:  if (alu_rsp.done) state_in = tcet_pkg::S_T_M1;
         tcet_pkg::S_T_M1:  if (alu_rsp.done) state_in = tcet_pkg::S_T_M2;
         tcet_pkg::S_T_M2:  if (alu_rsp.done) state_in = tcet_pkg::S_T_M3;
         tcet_pkg::S_T_M3:  if (alu_rsp.done) state_in = tcet_pkg::S_T_N0;
         tcet_pkg::S_T_N0:  if (alu_rsp.done) state_in = tcet_pkg::S_T_N1;
         tcet_pkg::S_T_N1:  if (alu_rsp.done) state_in = tcet_pkg::S_T_CHK;
         tcet_pkg::S_T_CHK: begin
            if (rescale) begin
               state_in = (tr_ff == 0 && ti_ff == 0) ? tcet_pkg::S_T_N0 : tcet_pkg::S_T_SQ;
            end else begin
               state_in = tcet_pkg::S_L_TOP;
            end
         end
         tcet_pkg::S_T_SQ:  if (alu_rsp.done) state_in = tcet_pkg::S_T_R0;
         tcet_pkg::S_T_R0:  if (alu_rsp.done) state_in = tcet_pkg::S_T_R1;
         tcet_pkg::S_T_R1:  if (alu_rsp.done) state_in = tcet_pkg::S_T_R2;
         tcet_pkg::S_T_R2:  if (alu_rsp.done) state_in = tcet_pkg::S_T_R3;
         tcet_pkg::S_T_R3:  if (alu_rsp.done) state_in = tcet_pkg::S_T_N0;
         tcet_pkg::S_L_TOP: begin
            state_in = (cnt_ff < max_iter_ff) ? tcet_pkg::S_L_D0 : tcet_pkg::S_P_INIT;
         end
         tcet_pkg::S_L_D0:  if (alu_rsp.done) state_in = tcet_pkg::S_L_D1;
         tcet_pkg::S_L_D1: begin
            if (alu_rsp.done) begin
               state_in = escape_hit ? tcet_pkg::S_DONE : tcet_pkg::S_L_N0;
            end
         end
         tcet_pkg::S_L_N0:  if (alu_rsp.done) state_in = tcet_pkg::S_L_N1;
         tcet_pkg::S_L_N1: begin
            if (alu_rsp.done) begin
               state_in = (pair_sum == 0) ? tcet_pkg::S_L_M0 : tcet_pkg::S_L_V0;
            end
         end
         tcet_pkg::S_L_V0:  if (alu_rsp.done) state_in = tcet_pkg::S_L_V1;
         tcet_pkg::S_L_V1:  if (alu_rsp.done) state_in = tcet_pkg::S_L_M0;
         tcet_pkg::S_L_M0:  if (alu_rsp.done) state_in = tcet_pkg::S_L_M1;
         tcet_pkg::S_L_M1:  if (alu_rsp.done) state_in = tcet_pkg::S_L_M2;
         tcet_pkg::S_L_M2:  if (alu_rsp.done) state_in = tcet_pkg::S_L_M3;
         tcet_pkg::S_L_M3:  if (alu_rsp.done) state_in = tcet_pkg::S_L_TOP;
         tcet_pkg::S_P_INIT: begin
            state_in = (per_ff == '0) ? tcet_pkg::S_DONE : tcet_pkg::S_P_RD;
         end
         tcet_pkg::S_P_RD:  state_in = tcet_pkg::S_P_S;
         tcet_pkg::S_P_S:   state_in = tcet_pkg::S_P_Q0;
         tcet_pkg::S_P_Q0:  if (alu_rsp.done) state_in = tcet_pkg::S_P_Q1;
         tcet_pkg::S_P_Q1: begin
            if (alu_rsp.done) begin
               if (tol_hit || (j_ff == per_ff - {{(PW-1){1'b0}}, 1'b1})) begin
                  state_in = tcet_pkg::S_DONE;
               end else begin
                  state_in = tcet_pkg::S_P_RD;
               end
            end
         end
         tcet_pkg::S_DONE:  if (slot_free) state_in = tcet_pkg::S_IDLE;
         default:           state_in = tcet_pkg::S_IDLE;
      endcase
   end

   // outputs: which operation the shared unit runs in each state
   always_comb begin
      is_call = 1'b1;
      call_op = tcet_pkg::ALU_MUL;
      mul_a   = '0;
      mul_b   = '0;
      div_num = '0;
      div_den = '0;
      div_neg = 1'b0;
      unique case (state_ff)
         tcet_pkg::S_T_M0: begin mul_a = ar_ff; mul_b = 64'(rot_cos_ff); end
         tcet_pkg::S_T_M1: begin mul_a = ai_ff; mul_b = 64'(rot_sin_ff); end
         tcet_pkg::S_T_M2: begin mul_a = ar_ff; mul_b = 64'(rot_sin_ff); end
         tcet_pkg::S_T_M3: begin mul_a = ai_ff; mul_b = 64'(rot_cos_ff); end
         tcet_pkg::S_T_N0: begin mul_a = tr_ff; mul_b = tr_ff; end
         tcet_pkg::S_T_N1: begin mul_a = ti_ff; mul_b = ti_ff; end
         tcet_pkg::S_T_SQ: call_op = tcet_pkg::ALU_SQRT;
         tcet_pkg::S_T_R0: begin mul_a = tr_ff; mul_b = $signed(TENTH_Q); end
         tcet_pkg::S_T_R1: begin
            call_op = tcet_pkg::ALU_DIV;
            div_num = wsum_ff;
            div_den = m_ff;
            div_neg = tr_ff[63];
         end
         tcet_pkg::S_T_R2: begin mul_a = ti_ff; mul_b = $signed(TENTH_Q); end
         tcet_pkg::S_T_R3: begin
            call_op = tcet_pkg::ALU_DIV;
            div_num = wsum_ff;
            div_den = m_ff;
            div_neg = ti_ff[63];
         end
         tcet_pkg::S_L_D0: begin mul_a = zr_ff; mul_b = tr_ff; end
         tcet_pkg::S_L_D1: begin mul_a = zi_ff; mul_b = ti_ff; end
         tcet_pkg::S_L_N0: begin mul_a = zr_ff; mul_b = zr_ff; end
         tcet_pkg::S_L_N1: begin mul_a = zi_ff; mul_b = zi_ff; end
         tcet_pkg::S_L_V0: begin
            call_op = tcet_pkg::ALU_DIV;
            div_num = 128'(tcet_pkg::mag64(zr_ff)) << FRAC_BITS;
            div_den = nt_ff;
            div_neg = zr_ff[63];
         end
         tcet_pkg::S_L_V1: begin
            // quotient of -x_im, so negative when x_im is positive
            call_op = tcet_pkg::ALU_DIV;
            div_num = 128'(tcet_pkg::mag64(zi_ff)) << FRAC_BITS;
            div_den = nt_ff;
            div_neg = zi_ff > 0;
         end
         tcet_pkg::S_L_M0: begin mul_a = 64'(rot_cos_ff); mul_b = wr_ff; end
         tcet_pkg::S_L_M1: begin mul_a = 64'(rot_sin_ff); mul_b = wi_ff; end
         tcet_pkg::S_L_M2: begin mul_a = 64'(rot_sin_ff); mul_b = wr_ff; end
         tcet_pkg::S_L_M3: begin mul_a = 64'(rot_cos_ff); mul_b = wi_ff; end
         tcet_pkg::S_P_Q0: begin mul_a = wr_ff; mul_b = wr_ff; end
         tcet_pkg::S_P_Q1: begin mul_a = wi_ff; mul_b = wi_ff; end
         default: is_call = 1'b0;
      endcase
   end

   always_comb begin
      alu_req.start = is_call && !wait_ff;
      alu_req.op    = call_op;
      alu_req.opa   = (call_op == tcet_pkg::ALU_MUL) ? tcet_pkg::mag64(mul_a) : '0;
      alu_req.opb   = (call_op == tcet_pkg::ALU_MUL) ? tcet_pkg::mag64(mul_b) : div_den;
      alu_req.wide  = (call_op == tcet_pkg::ALU_DIV) ? div_num : wsum_ff;
      alu_req.neg   = (call_op == tcet_pkg::ALU_MUL) ? (mul_a[63] ^ mul_b[63]) : div_neg;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcet_pkg::S_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rot_cos_ff   <= 32'sh1000_0000;
         rot_sin_ff   <= 32'sd0;
         max_iter_ff  <= 16'd1000;
         max_per_ff   <= 7'd10;
         tol_ff       <= 31'd26844;
      end else begin
         state_ff <= state_in;
         if (alu_rsp.done) begin
            wait_ff <= 1'b0;
         end else if (alu_req.start) begin
            wait_ff <= 1'b1;
         end
         if (state_ff == tcet_pkg::S_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_addr)
               tcet_pkg::CSR_ROT_COS:   rot_cos_ff  <= csr_wdata;
               tcet_pkg::CSR_ROT_SIN:   rot_sin_ff  <= csr_wdata;
               tcet_pkg::CSR_MAX_ITER:  max_iter_ff <= csr_wdata[15:0];
               tcet_pkg::CSR_MAX_PER:   max_per_ff  <= csr_wdata[6:0];
               tcet_pkg::CSR_TOLERANCE: tol_ff      <= csr_wdata[30:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers, loaded as each unit operation completes or in the states that use no unit
   always_ff @(posedge clock) begin
      if (state_ff == tcet_pkg::S_DONE && slot_free) begin
         rsp_outcome_ff <= fin_outcome_ff;
         rsp_count_ff   <= fin_count_ff;
      end
      unique case (state_ff)
         tcet_pkg::S_IDLE: begin
            if (accept) begin
               ar_ff    <= 64'(signed'(req_tdata[31:0]));
               ai_ff    <= 64'(signed'(req_tdata[63:32]));
               per_ff   <= per_cap[PW-1:0];
               pass2_ff <= 1'b0;
            end
         end
         tcet_pkg::S_T_M0, tcet_pkg::S_T_M2, tcet_pkg::S_L_D0,
         tcet_pkg::S_L_M0, tcet_pkg::S_L_M2, tcet_pkg::S_P_Q0: begin
            if (alu_rsp.done) t0_ff <= alu_rsp.res;
         end
         tcet_pkg::S_T_M1: if (alu_rsp.done) tr_ff <= tcet_pkg::sadd(pair_sum, ar_ff);
         tcet_pkg::S_T_M3: if (alu_rsp.done) ti_ff <= tcet_pkg::sadd(pair_diff, ai_ff);
         tcet_pkg::S_T_N0: begin
            if (alu_rsp.done) begin
               t0_ff   <= alu_rsp.res;
               wsum_ff <= alu_rsp.prod;
            end
         end
         tcet_pkg::S_T_N1: begin
            if (alu_rsp.done) begin
               nt_ff   <= pair_sum;
               wsum_ff <= wsum_ff + alu_rsp.prod;
            end
         end
         tcet_pkg::S_T_CHK: begin
            if (rescale) begin
               // t exactly zero takes 0.1 and skips the root
               if (tr_ff == 0 && ti_ff == 0) begin
                  tr_ff    <= $signed(TENTH_Q);
                  pass2_ff <= 1'b1;
               end
            end else begin
               lim_ff <= (nt_ff > $signed(LIM_CAP)) ? tcet_pkg::SMAX : $signed(lim_mul);
               zr_ff  <= -$signed(ONE_Q);
               zi_ff  <= '0;
               cnt_ff <= '0;
            end
         end
         tcet_pkg::S_T_SQ: if (alu_rsp.done) m_ff <= alu_rsp.res;
         tcet_pkg::S_T_R0, tcet_pkg::S_T_R2: if (alu_rsp.done) wsum_ff <= alu_rsp.prod;
         tcet_pkg::S_T_R1: if (alu_rsp.done) t0_ff <= alu_rsp.res;
         tcet_pkg::S_T_R3: begin
            if (alu_rsp.done) begin
               ti_ff    <= alu_rsp.res;
               tr_ff    <= t0_ff;
               pass2_ff <= 1'b1;
            end
         end
         tcet_pkg::S_L_D1: begin
            if (alu_rsp.done && escape_hit) begin
               fin_outcome_ff <= tcet_pkg::OUT_ESCAPED;
               fin_count_ff   <= cnt_ff;
            end
         end
         tcet_pkg::S_L_N0: if (alu_rsp.done) t0_ff <= alu_rsp.res;
         tcet_pkg::S_L_N1: begin
            if (alu_rsp.done) begin
               nt_ff <= pair_sum;
               if (pair_sum == 0) begin
                  wr_ff <= tcet_pkg::sadd(zr_ff, inv_re_sat);
                  wi_ff <= tcet_pkg::sadd(zi_ff, inv_im_sat);
               end
            end
         end
         tcet_pkg::S_L_V0: if (alu_rsp.done) wr_ff <= tcet_pkg::sadd(zr_ff, alu_rsp.res);
         tcet_pkg::S_L_V1: if (alu_rsp.done) wi_ff <= tcet_pkg::sadd(zi_ff, alu_rsp.res);
         tcet_pkg::S_L_M1: if (alu_rsp.done) zr_ff <= tcet_pkg::sadd(pair_sum, ar_ff);
         tcet_pkg::S_L_M3: begin
            if (alu_rsp.done) begin
               zi_ff  <= tcet_pkg::sadd(pair_diff, ai_ff);
               cnt_ff <= cnt_ff + 16'd1;
            end
         end
         tcet_pkg::S_P_INIT: begin
            j_ff           <= '0;
            fin_outcome_ff <= tcet_pkg::OUT_UNDECIDED;
            fin_count_ff   <= '0;
         end
         tcet_pkg::S_P_S: begin
            wr_ff <= tcet_pkg::ssub(zr_ff, $signed(ram_rd_data[63:0]));
            wi_ff <= tcet_pkg::ssub(zi_ff, $signed(ram_rd_data[127:64]));
         end
         tcet_pkg::S_P_Q1: begin
            if (alu_rsp.done) begin
               if (tol_hit) begin
                  fin_outcome_ff <= tcet_pkg::OUT_PERIODIC;
                  fin_count_ff   <= 16'(j_ff);
               end
               j_ff <= j_ff + {{(PW-1){1'b0}}, 1'b1};
            end
         end
         default: ;
      endcase
   end

   tcet_alu #(
      .FRAC_BITS(FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // orbit store entry: imaginary part high, real part low
   tcet_ram #(
      .WIDTH(128),
      .DEPTH(ORBIT_DEPTH)
   ) u_orbit (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data ({zi_ff, zr_ff}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == tcet_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff, rsp_outcome_ff};

`ifndef SYNTHESIS
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> wait_ff)
      else $error("unit finished with no operation outstanding");
   a_loop_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == tcet_pkg::S_L_D0 |-> cnt_ff < max_iter_ff)
      else $error("map step past the iteration limit");
   a_store_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> k_idx < 17'(per_ff))
      else $error("orbit write outside the kept window");
`endif

endmodule

`default_nettype wire
